FILE: src/urmc_pkg.sv
// Shared types, codes and reset constants for the ranging median controller.
package urmc_pkg;

    localparam int MAX_MEASURES = 32;
    localparam int TICK_W       = 16;

    localparam logic [7:0]  TRIG_LOW_RST   = 8'd4;
    localparam logic [7:0]  TRIG_HIGH_RST  = 8'd10;
    localparam logic [15:0] PING_TO_RST    = 16'd6000;
    localparam logic [15:0] ECHO_TO_RST    = 16'd40000;
    localparam logic [15:0] GAP_RST        = 16'd40000;
    localparam logic [5:0]  MEASURES_RST   = 6'd20;

    typedef enum logic [2:0] {
        CFG_TRIG_LOW  = 3'd0,
        CFG_TRIG_HIGH = 3'd1,
        CFG_PING_TO   = 3'd2,
        CFG_ECHO_TO   = 3'd3,
        CFG_GAP       = 3'd4,
        CFG_MEASURES  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OUTC_OK        = 2'd0,
        OUTC_ECHO_HIGH = 2'd1,
        OUTC_PING_TO   = 2'd2,
        OUTC_ECHO_TO   = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_WAIT,
        PH_MEASURE,
        PH_GAP
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MED_RD,
        ST_MED_OUT,
        ST_ACK
    } store_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_WAIT
    } top_state_t;

    typedef struct packed {
        logic [7:0]  trig_low;
        logic [7:0]  trig_high;
        logic [15:0] ping_to;
        logic [15:0] echo_to;
        logic [15:0] gap;
        logic [5:0]  measures;
    } cfg_t;

    // Outcome of one tick as decided by the sequencer
    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              mdone;
        outcome_t          outcome;
        logic              store;
        logic [TICK_W-1:0] width;
        logic              report;
        logic              clear;
    } step_t;

    typedef struct packed {
        logic              valid;
        logic              clear;
        logic              insert;
        logic              report;
        logic [TICK_W-1:0] width;
    } store_cmd_t;

    typedef struct packed {
        logic              done;
        logic              fail;
        logic [TICK_W-1:0] median;
    } store_rsp_t;

    typedef struct packed {
        logic              trigger;
        logic              busy;
        logic              mdone;
        outcome_t          outcome;
        logic              burst_done;
        logic [TICK_W-1:0] echo_us;
        logic              burst_status;
    } res_t;

endpackage

FILE: src/urmc_ifs.sv
// Channel interfaces: tick samples, tick results and register writes.
interface urmc_sample_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface urmc_result_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        busy_res;
    logic        measure_done;
    logic [1:0]  outcome;
    logic        burst_done;
    logic [15:0] echo_us;
    logic        burst_status;

    modport source (output valid, output trigger_level, output busy_res,
                    output measure_done, output outcome, output burst_done,
                    output echo_us, output burst_status, input ready);
    modport sink   (input valid, input trigger_level, input busy_res,
                    input measure_done, input outcome, input burst_done,
                    input echo_us, input burst_status, output ready);
endinterface

interface urmc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/urmc_seq.sv
// Measurement sequencer: phase, tick counter and measurement index.
module urmc_seq #(
    parameter int MaxMeasures = urmc_pkg::MAX_MEASURES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  logic            start_req,
    input  logic            echo_level,
    input  urmc_pkg::cfg_t  cfg_reg,
    output urmc_pkg::step_t step
);

    localparam int CW = $clog2(MaxMeasures + 1);
    localparam int BW = (CW > 6) ? CW : 6;

    urmc_pkg::phase_t  phase_reg, phase_next;
    logic [15:0]       tick_reg, tick_next;
    logic [CW-1:0]     midx_reg, midx_next;

    logic [15:0]       tick_inc;
    logic [CW-1:0]     midx_inc;
    logic [BW-1:0]     n_ext;
    logic [BW-1:0]     burst_len;
    logic              last_measure;
    logic              go_gap;
    logic              go_next;

    assign tick_inc     = tick_reg + 16'd1;
    assign midx_inc     = midx_reg + 1'b1;
    assign n_ext        = BW'(cfg_reg.measures);
    assign burst_len    = (n_ext == '0) ? BW'(1) :
                          ((n_ext > BW'(MaxMeasures)) ? BW'(MaxMeasures) : n_ext);
    assign last_measure = (BW'(midx_inc) >= burst_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= urmc_pkg::PH_IDLE;
            tick_reg  <= '0;
            midx_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            midx_reg  <= midx_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        midx_next    = midx_reg;
        go_gap       = 1'b0;
        go_next      = 1'b0;
        step.mdone   = 1'b0;
        step.outcome = urmc_pkg::OUTC_OK;
        step.store   = 1'b0;
        step.width   = tick_inc;
        step.report  = 1'b0;
        step.clear   = 1'b0;

        unique case (phase_reg)
            urmc_pkg::PH_IDLE:
            begin
                if (start_req)
                begin
                    midx_next  = '0;
                    tick_next  = '0;
                    phase_next = urmc_pkg::PH_LOW;
                    step.clear = 1'b1;
                end
            end
            urmc_pkg::PH_LOW:
            begin
                tick_next = tick_inc;
                if (tick_inc >= {8'h00, cfg_reg.trig_low})
                begin
                    phase_next = urmc_pkg::PH_HIGH;
                    tick_next  = '0;
                end
            end
            urmc_pkg::PH_HIGH:
            begin
                tick_next = tick_inc;
                if (tick_inc >= {8'h00, cfg_reg.trig_high})
                begin
                    tick_next = '0;
                    if (echo_level)
                    begin
                        step.mdone   = 1'b1;
                        step.outcome = urmc_pkg::OUTC_ECHO_HIGH;
                        go_gap       = 1'b1;
                    end
                    else
                    begin
                        phase_next = urmc_pkg::PH_WAIT;
                    end
                end
            end
            urmc_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    phase_next = urmc_pkg::PH_MEASURE;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg_reg.ping_to)
                    begin
                        step.mdone   = 1'b1;
                        step.outcome = urmc_pkg::OUTC_PING_TO;
                        go_next      = 1'b1;
                    end
                end
            end
            urmc_pkg::PH_MEASURE:
            begin
                tick_next = tick_inc;
                if (!echo_level)
                begin
                    step.mdone = 1'b1;
                    step.store = 1'b1;
                    go_gap     = 1'b1;
                end
                else if (tick_inc >= cfg_reg.echo_to)
                begin
                    step.mdone   = 1'b1;
                    step.outcome = urmc_pkg::OUTC_ECHO_TO;
                    step.store   = 1'b1;
                    go_next      = 1'b1;
                end
            end
            urmc_pkg::PH_GAP:
            begin
                tick_next = tick_inc;
                if (tick_inc >= cfg_reg.gap)
                begin
                    go_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = urmc_pkg::PH_IDLE;
                tick_next  = '0;
            end
        endcase

        // a zero gap moves straight on to the next measurement
        if (go_gap)
        begin
            if (cfg_reg.gap == '0)
            begin
                go_next = 1'b1;
            end
            else
            begin
                phase_next = urmc_pkg::PH_GAP;
                tick_next  = '0;
            end
        end

        if (go_next)
        begin
            midx_next = midx_inc;
            tick_next = '0;
            if (last_measure)
            begin
                phase_next  = urmc_pkg::PH_IDLE;
                step.report = 1'b1;
            end
            else
            begin
                phase_next = urmc_pkg::PH_LOW;
            end
        end

        step.trigger = (phase_next == urmc_pkg::PH_HIGH);
        step.busy    = (phase_next != urmc_pkg::PH_IDLE);
    end

endmodule

FILE: src/urmc_store.sv
// Sorted width store: insertion walk over a memory with registered read, and median read.
module urmc_store #(
    parameter int MaxMeasures = urmc_pkg::MAX_MEASURES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  urmc_pkg::store_cmd_t cmd,
    output urmc_pkg::store_rsp_t rsp
);

    localparam int AW = (MaxMeasures > 1) ? $clog2(MaxMeasures) : 1;
    localparam int CW = $clog2(MaxMeasures + 1);

    logic [15:0] mem [MaxMeasures];
    logic [15:0] rdata_reg;

    urmc_pkg::store_state_t state_reg, state_next;
    logic [CW-1:0]          vc_reg, vc_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [15:0]            w_reg, w_next;
    logic                   report_reg, report_next;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [15:0]            wdata;
    logic [AW-1:0]          raddr;
    logic [CW-1:0]          vc_dec;
    logic [CW-1:0]          med_idx;
    logic [AW-1:0]          pos_dec;
    logic [AW-1:0]          pos_dec2;
    logic                   insert_ok;

    assign vc_dec    = vc_reg - 1'b1;
    assign med_idx   = vc_dec >> 1;
    assign pos_dec   = pos_reg - 1'b1;
    assign pos_dec2  = pos_dec - 1'b1;
    assign insert_ok = cmd.insert && (vc_reg < CW'(MaxMeasures));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= urmc_pkg::ST_IDLE;
            vc_reg     <= '0;
            pos_reg    <= '0;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            vc_reg     <= vc_next;
            pos_reg    <= pos_next;
            report_reg <= report_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        vc_next     = vc_reg;
        pos_next    = pos_reg;
        w_next      = w_reg;
        report_next = report_reg;
        we          = 1'b0;
        waddr       = pos_reg;
        wdata       = w_reg;
        raddr       = pos_dec;
        rsp.done    = 1'b0;
        rsp.fail    = 1'b0;
        rsp.median  = '0;

        unique case (state_reg)
            urmc_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    report_next = cmd.report;
                    if (cmd.clear)
                    begin
                        vc_next = '0;
                    end
                    else if (insert_ok && (vc_reg == '0))
                    begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = cmd.width;
                        vc_next    = vc_reg + 1'b1;
                        state_next = cmd.report ? urmc_pkg::ST_MED_RD : urmc_pkg::ST_ACK;
                    end
                    else if (insert_ok)
                    begin
                        // fetch the top entry and start the walk down from the free slot
                        raddr      = vc_dec[AW-1:0];
                        pos_next   = vc_reg[AW-1:0];
                        w_next     = cmd.width;
                        state_next = urmc_pkg::ST_WALK;
                    end
                    else
                    begin
                        state_next = cmd.report ? urmc_pkg::ST_MED_RD : urmc_pkg::ST_ACK;
                    end
                end
            end
            urmc_pkg::ST_WALK:
            begin
                we = 1'b1;
                if ((pos_reg != '0) && (rdata_reg > w_reg))
                begin
                    // shift the larger entry up one slot and fetch the next one down
                    wdata    = rdata_reg;
                    pos_next = pos_dec;
                    raddr    = pos_dec2;
                end
                else
                begin
                    wdata      = w_reg;
                    vc_next    = vc_reg + 1'b1;
                    state_next = report_reg ? urmc_pkg::ST_MED_RD : urmc_pkg::ST_ACK;
                end
            end
            urmc_pkg::ST_MED_RD:
            begin
                raddr      = med_idx[AW-1:0];
                state_next = urmc_pkg::ST_MED_OUT;
            end
            urmc_pkg::ST_MED_OUT:
            begin
                rsp.done   = 1'b1;
                rsp.fail   = (vc_reg == '0);
                rsp.median = (vc_reg == '0) ? '0 : rdata_reg;
                state_next = urmc_pkg::ST_IDLE;
            end
            urmc_pkg::ST_ACK:
            begin
                rsp.done   = 1'b1;
                state_next = urmc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = urmc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/ultrasonic_ranging_median_controller.sv
// Ultrasonic ranging controller with trigger sequencing and median selection.
//
// One transaction on the sample channel is one microsecond tick carrying the
// start request and the echo pin level; each tick gives exactly one
// transaction on the result channel with the trigger level, busy flag,
// measurement outcome and, at the end of a burst, the lower median width.
// The user must write registers via the cfg channel (always ready) only while idle; it is not enforced.
//
// Timing: a tick that stores no width and ends no burst is answered in the cycle
// after it is taken. A tick that stores a width walks the sorted memory from
// its top, one entry per cycle; a tick that ends a burst also waits for the
// median read. The worst case is set by the insertion walk over a full store.
// One tick is in work at a time; the next tick is taken no earlier than the
// cycle in which the current one's result is taken, so ticks without a store
// can follow back to back.
//
// Reset puts the sequencer in idle and empties the width store; registers
// return to their defaults. A stalled result holds the output register and
// blocks further ticks until it is taken.
module ultrasonic_ranging_median_controller #(
    parameter int MaxMeasures = urmc_pkg::MAX_MEASURES
) (
    input  logic          clk,
    input  logic          rst_n,
    urmc_sample_if.sink   sample,
    urmc_result_if.source result,
    urmc_cfg_if.sink      cfg
);

    urmc_pkg::cfg_t       cfg_reg;
    urmc_pkg::top_state_t state_reg, state_next;
    urmc_pkg::res_t       out_reg, out_next;
    urmc_pkg::res_t       hold_reg, hold_next;
    logic                 out_valid_reg, out_valid_next;

    urmc_pkg::step_t      step;
    urmc_pkg::store_cmd_t cmd;
    urmc_pkg::store_rsp_t rsp;
    urmc_pkg::res_t       step_res;
    logic                 accept;
    logic                 need_store;

    assign cfg.ready    = 1'b1;
    assign sample.ready = (state_reg == urmc_pkg::TOP_IDLE) && (!out_valid_reg || result.ready);
    assign accept       = sample.valid && sample.ready;
    assign need_store   = step.store || step.report;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trig_low  <= urmc_pkg::TRIG_LOW_RST;
            cfg_reg.trig_high <= urmc_pkg::TRIG_HIGH_RST;
            cfg_reg.ping_to   <= urmc_pkg::PING_TO_RST;
            cfg_reg.echo_to   <= urmc_pkg::ECHO_TO_RST;
            cfg_reg.gap       <= urmc_pkg::GAP_RST;
            cfg_reg.measures  <= urmc_pkg::MEASURES_RST;
        end
        else if (cfg.valid)
        begin
            unique case (urmc_pkg::cfg_idx_t'(cfg.index))
                urmc_pkg::CFG_TRIG_LOW:  cfg_reg.trig_low  <= cfg.data[7:0];
                urmc_pkg::CFG_TRIG_HIGH: cfg_reg.trig_high <= cfg.data[7:0];
                urmc_pkg::CFG_PING_TO:   cfg_reg.ping_to   <= cfg.data;
                urmc_pkg::CFG_ECHO_TO:   cfg_reg.echo_to   <= cfg.data;
                urmc_pkg::CFG_GAP:       cfg_reg.gap       <= cfg.data;
                urmc_pkg::CFG_MEASURES:  cfg_reg.measures  <= cfg.data[5:0];
                default:                 ;
            endcase
        end
    end

    urmc_seq #(
        .MaxMeasures (MaxMeasures)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (accept),
        .start_req  (sample.start_req),
        .echo_level (sample.echo_level),
        .cfg_reg    (cfg_reg),
        .step       (step)
    );

    assign cmd.valid  = accept && (need_store || step.clear);
    assign cmd.clear  = step.clear;
    assign cmd.insert = step.store;
    assign cmd.report = step.report;
    assign cmd.width  = step.width;

    urmc_store #(
        .MaxMeasures (MaxMeasures)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    always_comb
    begin
        step_res.trigger      = step.trigger;
        step_res.busy         = step.busy;
        step_res.mdone        = step.mdone;
        step_res.outcome      = step.outcome;
        step_res.burst_done   = step.report;
        step_res.echo_us      = '0;
        step_res.burst_status = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= urmc_pkg::TOP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_next       = out_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && !result.ready;

        unique case (state_reg)
            urmc_pkg::TOP_IDLE:
            begin
                if (accept)
                begin
                    if (need_store)
                    begin
                        // hold the tick's fields until the store has finished
                        hold_next  = step_res;
                        state_next = urmc_pkg::TOP_WAIT;
                    end
                    else
                    begin
                        out_next       = step_res;
                        out_valid_next = 1'b1;
                    end
                end
            end
            urmc_pkg::TOP_WAIT:
            begin
                if (rsp.done)
                begin
                    out_next = hold_reg;
                    if (hold_reg.burst_done)
                    begin
                        out_next.echo_us      = rsp.median;
                        out_next.burst_status = rsp.fail;
                    end
                    out_valid_next = 1'b1;
                    state_next     = urmc_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = urmc_pkg::TOP_IDLE;
            end
        endcase
    end

    assign result.valid         = out_valid_reg;
    assign result.trigger_level = out_reg.trigger;
    assign result.busy_res      = out_reg.busy;
    assign result.measure_done  = out_reg.mdone;
    assign result.outcome       = out_reg.outcome;
    assign result.burst_done    = out_reg.burst_done;
    assign result.echo_us       = out_reg.echo_us;
    assign result.burst_status  = out_reg.burst_status;

endmodule

FILE: tb/sv/tb_ultrasonic_ranging_median_controller.sv
// Testbench for the ranging median controller: directed table, random bursts, tick predictor.
module tb_ultrasonic_ranging_median_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import urmc_pkg::*;

    localparam int   LATENCY_CYCLES    = MAX_MEASURES + 8;
    localparam int   SETTINGS_N        = 8;
    localparam int   TICKS_PER_SETTING = 80;
    localparam res_t IDLE_RES          = '0;
    localparam res_t BUSY_RES          = res_t'{1'b0, 1'b1, 1'b0, OUTC_OK, 1'b0, 16'd0, 1'b0};
    localparam res_t HIGH_RES          = res_t'{1'b1, 1'b1, 1'b0, OUTC_OK, 1'b0, 16'd0, 1'b0};

    typedef enum logic {
        ROW_CFG,
        ROW_TICK
    } row_kind_t;

    typedef struct {
        row_kind_t kind;
        cfg_t      regs;
        logic      start;
        logic      echo;
        int        reps;
        logic      typed;
        res_t      want;
    } row_t;

    logic clk;
    logic rst_n;

    urmc_sample_if sample_ch ();
    urmc_result_if result_ch ();
    urmc_cfg_if    cfg_ch ();

    ultrasonic_ranging_median_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predicted controller state and register copy
    cfg_t        cur_cfg;
    phase_t      rg_phase;
    logic [15:0] rg_tick;
    int          rg_index;
    int          rg_count;
    logic [15:0] rg_widths [MAX_MEASURES];

    res_t ranging_q [$];
    row_t plan [$];
    int   mismatches;
    logic quiet;
    logic typed_check;
    res_t typed_want;
    logic echo_lvl;
    int   echo_run;
    int   lo_span;
    int   hi_span;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tb_ultrasonic_ranging_median_controller failed");
        $finish;
    end

    function automatic int burst_length();
        if (cur_cfg.measures == 6'd0)
            return 1;
        if (cur_cfg.measures > MAX_MEASURES)
            return MAX_MEASURES;
        return int'(cur_cfg.measures);
    endfunction

    // Insert after any equal widths so the store stays ascending and stable
    function automatic void insert_width(input logic [15:0] w);
        int p;
        p = 0;
        if (rg_count >= MAX_MEASURES)
            return;
        while (p < rg_count && rg_widths[p] <= w)
            p++;
        for (int i = rg_count; i > p; i--)
            rg_widths[i] = rg_widths[i - 1];
        rg_widths[p] = w;
        rg_count++;
    endfunction

    function automatic res_t step_ranging(input logic start, input logic echo);
        res_t r;
        logic ended;
        logic gap_follows;
        r           = '0;
        ended       = 1'b0;
        gap_follows = 1'b0;
        case (rg_phase)
            PH_IDLE:
            begin
                if (start)
                begin
                    rg_index = 0;
                    rg_count = 0;
                    rg_tick  = '0;
                    rg_phase = PH_LOW;
                end
            end
            PH_LOW:
            begin
                rg_tick = rg_tick + 16'd1;
                if (rg_tick >= cur_cfg.trig_low)
                begin
                    rg_phase = PH_HIGH;
                    rg_tick  = '0;
                end
            end
            PH_HIGH:
            begin
                rg_tick = rg_tick + 16'd1;
                if (rg_tick >= cur_cfg.trig_high)
                begin
                    rg_tick = '0;
                    if (echo)
                    begin
                        r.mdone     = 1'b1;
                        r.outcome   = OUTC_ECHO_HIGH;
                        ended       = 1'b1;
                        gap_follows = 1'b1;
                    end
                    else
                        rg_phase = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (echo)
                begin
                    rg_phase = PH_MEASURE;
                    rg_tick  = '0;
                end
                else
                begin
                    rg_tick = rg_tick + 16'd1;
                    if (rg_tick >= cur_cfg.ping_to)
                    begin
                        r.mdone   = 1'b1;
                        r.outcome = OUTC_PING_TO;
                        ended     = 1'b1;
                    end
                end
            end
            PH_MEASURE:
            begin
                rg_tick = rg_tick + 16'd1;
                // echo low on the timeout tick still counts as ok
                if (!echo)
                begin
                    r.mdone     = 1'b1;
                    r.outcome   = OUTC_OK;
                    insert_width(rg_tick);
                    ended       = 1'b1;
                    gap_follows = 1'b1;
                end
                else if (rg_tick >= cur_cfg.echo_to)
                begin
                    r.mdone   = 1'b1;
                    r.outcome = OUTC_ECHO_TO;
                    insert_width(rg_tick);
                    ended     = 1'b1;
                end
            end
            PH_GAP:
            begin
                rg_tick = rg_tick + 16'd1;
                if (rg_tick >= cur_cfg.gap)
                    ended = 1'b1;
            end
            default:
            begin
                rg_phase = PH_IDLE;
                rg_tick  = '0;
            end
        endcase

        if (ended && gap_follows && cur_cfg.gap != 16'd0)
        begin
            rg_phase = PH_GAP;
            rg_tick  = '0;
        end
        else if (ended)
        begin
            rg_index++;
            rg_tick = '0;
            if (rg_index >= burst_length())
            begin
                r.burst_done = 1'b1;
                if (rg_count == 0)
                    r.burst_status = 1'b1;
                else
                    r.echo_us = rg_widths[(rg_count - 1) / 2];
                rg_phase = PH_IDLE;
            end
            else
                rg_phase = PH_LOW;
        end

        r.trigger = (rg_phase == PH_HIGH);
        r.busy    = (rg_phase != PH_IDLE);
        return r;
    endfunction

    function automatic string show(input res_t r);
        return $sformatf("trig=%0b busy=%0b mdone=%0b outc=%0d bdone=%0b echo_us=%0d status=%0b",
                         r.trigger, r.busy, r.mdone, r.outcome, r.burst_done, r.echo_us,
                         r.burst_status);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%t mismatch: %s", $realtime, msg);
    endtask

    // Check results and predict accepted ticks in one place so ordering within a step is fixed
    always @(posedge clk)
    begin : watch
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.trigger      = result_ch.trigger_level;
                got.busy         = result_ch.busy_res;
                got.mdone        = result_ch.measure_done;
                got.outcome      = outcome_t'(result_ch.outcome);
                got.burst_done   = result_ch.burst_done;
                got.echo_us      = result_ch.echo_us;
                got.burst_status = result_ch.burst_status;
                if (ranging_q.size() == 0)
                    note_mismatch({"unexpected transaction ", show(got)});
                else
                begin
                    want = ranging_q.pop_front();
                    if (got !== want)
                        note_mismatch({"expected ", show(want), " got ", show(got)});
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                want = step_ranging(sample_ch.start_req, sample_ch.echo_level);
                if (typed_check)
                    want = typed_want;
                ranging_q.push_back(want);
            end
        end
    end

    // Result side back-pressure
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 15) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    task automatic send_tick(input logic start, input logic echo, input logic chk,
                             input res_t want);
        if (!quiet && $urandom_range(0, 15) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.start_req  <= start;
        sample_ch.echo_level <= echo;
        typed_check          <= chk;
        typed_want           <= want;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_empty();
        @(posedge clk);
        while (ranging_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Hold the sender until the predicted burst has run out
    task automatic finish_burst();
        sample_ch.valid <= 1'b0;
        wait_empty();
        while (rg_phase != PH_IDLE)
        begin
            repeat (32) send_tick(1'b0, 1'b0, 1'b0, IDLE_RES);
            sample_ch.valid <= 1'b0;
            wait_empty();
        end
    endtask

    task automatic write_regs(input cfg_t regs);
        cfg_idx_t    idx;
        logic [15:0] val;
        repeat (LATENCY_CYCLES) @(posedge clk);
        for (int i = 0; i <= int'(CFG_MEASURES); i++)
        begin
            idx = cfg_idx_t'(i);
            case (idx)
                CFG_TRIG_LOW:  val = {8'd0, regs.trig_low};
                CFG_TRIG_HIGH: val = {8'd0, regs.trig_high};
                CFG_PING_TO:   val = regs.ping_to;
                CFG_ECHO_TO:   val = regs.echo_to;
                CFG_GAP:       val = regs.gap;
                default:       val = {10'd0, regs.measures};
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= val;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_cfg = regs;
        lo_span = int'(regs.trig_low) + int'(regs.trig_high) + int'(regs.ping_to) + 4;
        hi_span = int'(regs.echo_to) + 3;
    endtask

    function automatic void tick_rows(input logic s, input logic e, input int n);
        plan.push_back(row_t'{ROW_TICK, '0, s, e, n, 1'b0, IDLE_RES});
    endfunction

    function automatic void check_rows(input logic s, input logic e, input int n,
                                       input res_t want);
        plan.push_back(row_t'{ROW_TICK, '0, s, e, n, 1'b1, want});
    endfunction

    function automatic void cfg_rows(input cfg_t regs);
        plan.push_back(row_t'{ROW_CFG, regs, 1'b0, 1'b0, 0, 1'b0, IDLE_RES});
    endfunction

    function automatic void build_plan();
        // reset timing with one measurement that runs into the ping timeout
        check_rows(1'b0, 1'b0, 3, IDLE_RES);
        check_rows(1'b0, 1'b1, 1, IDLE_RES);
        cfg_rows(cfg_t'{TRIG_LOW_RST, TRIG_HIGH_RST, 16'd50, ECHO_TO_RST, GAP_RST, 6'd1});
        check_rows(1'b1, 1'b0, 1, BUSY_RES);
        check_rows(1'b0, 1'b1, 3, BUSY_RES);
        check_rows(1'b1, 1'b0, 1, HIGH_RES);
        tick_rows(1'b0, 1'b0, 10);
        check_rows(1'b0, 1'b0, 50,
                   res_t'{1'b0, 1'b0, 1'b1, OUTC_PING_TO, 1'b1, 16'd0, 1'b1});
        // zero durations and a zero burst length, echo already high
        cfg_rows(cfg_t'{8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 6'd0});
        check_rows(1'b1, 1'b1, 1, BUSY_RES);
        check_rows(1'b0, 1'b0, 1, HIGH_RES);
        check_rows(1'b0, 1'b1, 1, res_t'{1'b0, 1'b0, 1'b1, OUTC_ECHO_HIGH, 1'b1, 16'd0, 1'b1});
        // longest trigger, then an echo that runs into its timeout
        cfg_rows(cfg_t'{8'd255, 8'd255, 16'hFFFF, 16'd64, 16'hFFFF, 6'd1});
        check_rows(1'b1, 1'b0, 1, BUSY_RES);
        tick_rows(1'b0, 1'b1, 254);
        check_rows(1'b0, 1'b0, 1, HIGH_RES);
        tick_rows(1'b0, 1'b0, 254);
        check_rows(1'b0, 1'b0, 1, BUSY_RES);
        check_rows(1'b0, 1'b1, 1, BUSY_RES);
        check_rows(1'b0, 1'b1, 64,
                   res_t'{1'b0, 1'b0, 1'b1, OUTC_ECHO_TO, 1'b1, 16'd64, 1'b0});
        // ok on the timeout tick, ping timeout, echo timeout, then the median
        cfg_rows(cfg_t'{8'd1, 8'd1, 16'd2, 16'd2, 16'd0, 6'd3});
        check_rows(1'b1, 1'b0, 1, BUSY_RES);
        check_rows(1'b0, 1'b0, 1, HIGH_RES);
        tick_rows(1'b0, 1'b0, 1);
        tick_rows(1'b0, 1'b1, 2);
        check_rows(1'b0, 1'b0, 1, res_t'{1'b0, 1'b1, 1'b1, OUTC_OK, 1'b0, 16'd0, 1'b0});
        tick_rows(1'b0, 1'b0, 3);
        check_rows(1'b0, 1'b0, 1, res_t'{1'b0, 1'b1, 1'b1, OUTC_PING_TO, 1'b0, 16'd0, 1'b0});
        tick_rows(1'b0, 1'b0, 2);
        tick_rows(1'b0, 1'b1, 2);
        check_rows(1'b0, 1'b1, 1, res_t'{1'b0, 1'b0, 1'b1, OUTC_ECHO_TO, 1'b1, 16'd2, 1'b0});
    endfunction

    function automatic cfg_t random_regs(input int setting);
        cfg_t regs;
        regs.trig_low  = 8'($urandom_range(0, 4));
        regs.trig_high = 8'($urandom_range(0, 4));
        regs.ping_to   = 16'($urandom_range(0, 12));
        regs.echo_to   = 16'($urandom_range(0, 16));
        regs.gap       = 16'($urandom_range(0, 6));
        case (setting)
            0:       regs.measures = 6'd63;
            1:       regs.measures = 6'd32;
            2:       regs.measures = 6'd0;
            default: regs.measures = 6'($urandom_range(1, 8));
        endcase
        return regs;
    endfunction

    // Echo as alternating runs sized around the configured windows, plus some noise
    task automatic random_tick();
        logic e;
        if (echo_run == 0)
        begin
            echo_lvl = !echo_lvl;
            echo_run = echo_lvl ? $urandom_range(1, hi_span) : $urandom_range(1, lo_span);
        end
        echo_run--;
        e = echo_lvl;
        if ($urandom_range(0, 19) == 0)
            e = !e;
        send_tick($urandom_range(0, 3) == 0, e, 1'b0, IDLE_RES);
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        sample_ch.valid      <= 1'b0;
        sample_ch.start_req  <= 1'b0;
        sample_ch.echo_level <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_TRIG_LOW;
        cfg_ch.data          <= 16'd0;
        typed_check          <= 1'b0;
        typed_want           <= IDLE_RES;
        quiet      = 1'b0;
        mismatches = 0;
        echo_lvl   = 1'b0;
        echo_run   = 0;
        cur_cfg    = cfg_t'{TRIG_LOW_RST, TRIG_HIGH_RST, PING_TO_RST, ECHO_TO_RST, GAP_RST,
                            MEASURES_RST};
        lo_span    = 8;
        hi_span    = 8;
        rg_phase   = PH_IDLE;
        rg_tick    = '0;
        rg_index   = 0;
        rg_count   = 0;
        build_plan();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                finish_burst();
                write_regs(plan[i].regs);
            end
            else
            begin
                for (int k = 1; k <= plan[i].reps; k++)
                    send_tick(plan[i].start, plan[i].echo, plan[i].typed && k == plan[i].reps,
                              plan[i].want);
            end
        end

        for (int s = 0; s < SETTINGS_N; s++)
        begin
            // no idling on either side for the last setting
            quiet = (s == SETTINGS_N - 1);
            finish_burst();
            write_regs(random_regs(s));
            repeat (TICKS_PER_SETTING) random_tick();
        end
        finish_burst();

        repeat (LATENCY_CYCLES) @(posedge clk);
        if (mismatches == 0 && ranging_q.size() == 0)
            $display("tb_ultrasonic_ranging_median_controller passed");
        else
            $display("tb_ultrasonic_ranging_median_controller failed");
        $finish;
    end

endmodule

FILE: ultrasonic_ranging_median_controller.f
src/urmc_pkg.sv
src/urmc_ifs.sv
src/urmc_seq.sv
src/urmc_store.sv
src/ultrasonic_ranging_median_controller.sv
tb/sv/tb_ultrasonic_ranging_median_controller.sv
